// ===== design/transmitter_power_sequencer_assert.svh =====
// Assertion macros shared by the sequencer modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef TRANSMITTER_POWER_SEQUENCER_ASSERT_SVH
`define TRANSMITTER_POWER_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define TPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tps_pkg.sv =====
`default_nettype none
package tps_pkg;

  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 16;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int TPS_QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_POLL_LIMIT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FAULT_WINDOW = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RESETS   = 2'd2;

  localparam logic [15:0] POLL_LIMIT_RST   = 16'd1800;
  localparam logic [7:0]  FAULT_WINDOW_RST = 8'd10;
  localparam logic [3:0]  MAX_RESETS_RST   = 4'd3;

  // client requests
  localparam logic [2:0] REQ_INVALID  = 3'd0;
  localparam logic [2:0] REQ_STATUS   = 3'd1;
  localparam logic [2:0] REQ_POWERON  = 3'd2;
  localparam logic [2:0] REQ_POWEROFF = 3'd3;
  localparam logic [2:0] REQ_STANDBY  = 3'd4;
  localparam logic [2:0] REQ_OPERATE  = 3'd5;
  localparam logic [2:0] REQ_RESET    = 3'd6;

  // transmitter commands
  localparam logic [2:0] SEND_NONE     = 3'd0;
  localparam logic [2:0] SEND_POLL     = 3'd1;
  localparam logic [2:0] SEND_POWERON  = 3'd2;
  localparam logic [2:0] SEND_POWEROFF = 3'd3;
  localparam logic [2:0] SEND_STANDBY  = 3'd4;
  localparam logic [2:0] SEND_OPERATE  = 3'd5;
  localparam logic [2:0] SEND_RESET    = 3'd6;

  localparam logic [4:0] MSG_NONE          = 5'd0;
  localparam logic [4:0] MSG_BAD_REQUEST   = 5'd1;
  localparam logic [4:0] MSG_STATUS        = 5'd2;
  localparam logic [4:0] MSG_LOCAL         = 5'd3;
  localparam logic [4:0] MSG_UNKNOWN_CMD   = 5'd4;
  localparam logic [4:0] MSG_ALREADY_ON    = 5'd5;
  localparam logic [4:0] MSG_ABORT         = 5'd6;
  localparam logic [4:0] MSG_WARMING       = 5'd7;
  localparam logic [4:0] MSG_WARM_STBY     = 5'd8;
  localparam logic [4:0] MSG_WARM_NO_STBY  = 5'd9;
  localparam logic [4:0] MSG_NOT_ON        = 5'd10;
  localparam logic [4:0] MSG_ALREADY_OFF   = 5'd11;
  localparam logic [4:0] MSG_COOLING       = 5'd12;
  localparam logic [4:0] MSG_COOL_DONE     = 5'd13;
  localparam logic [4:0] MSG_STBY_NO_COOL  = 5'd14;
  localparam logic [4:0] MSG_TX_OFF        = 5'd15;
  localparam logic [4:0] MSG_ALREADY_STBY  = 5'd16;
  localparam logic [4:0] MSG_IN_STBY       = 5'd17;
  localparam logic [4:0] MSG_NO_STBY       = 5'd18;
  localparam logic [4:0] MSG_ALREADY_OPER  = 5'd19;
  localparam logic [4:0] MSG_IN_OPER       = 5'd20;
  localparam logic [4:0] MSG_NO_OPER       = 5'd21;
  localparam logic [4:0] MSG_RESET_DONE    = 5'd22;
  localparam logic [4:0] MSG_RESET_FAIL    = 5'd23;
  localparam logic [4:0] MSG_FAULT         = 5'd24;
  localparam logic [4:0] MSG_SENT          = 5'd25;
  localparam logic [4:0] MSG_AUTO_RESET    = 5'd26;

  // bit positions in the report flag vector
  localparam int FLG_ON     = 0;
  localparam int FLG_STBY   = 1;
  localparam int FLG_FAULT  = 2;
  localparam int FLG_WARM   = 3;
  localparam int FLG_COOL   = 4;
  localparam int FLG_HV     = 5;
  localparam int FLG_REMOTE = 6;

  typedef enum logic [4:0] {
    ST_IDLE       = 5'd0,
    ST_CHECK      = 5'd1,
    ST_WAIT_ON    = 5'd2,
    ST_WAIT_WARM  = 5'd3,
    ST_WARM_CHECK = 5'd4,
    ST_OFF_STBY   = 5'd5,
    ST_COOL_START = 5'd6,
    ST_COOL_END   = 5'd7,
    ST_WAIT_STBY  = 5'd8,
    ST_WAIT_OPER  = 5'd9,
    ST_WAIT_RESET = 5'd10
  } tps_step_t;

  typedef enum logic [1:0] {
    KIND_REQ         = 2'd0,
    KIND_REQ_INVALID = 2'd1,
    KIND_REPORT      = 2'd2
  } tps_kind_t;

  typedef struct packed {
    tps_kind_t   kind;
    logic [2:0]  req;
    logic        ok;
    logic [6:0]  flags;
    logic [31:0] t;
  } tps_item_t;

  typedef struct packed {
    logic [15:0] poll_limit;
    logic [7:0]  fault_window;
    logic [3:0]  max_resets;
  } tps_cfg_t;

endpackage
`default_nettype wire

// ===== design/tps_front.sv =====
`default_nettype none
module tps_front (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // request[2:0], poll_ok, unit_on, in_standby, fault_summary, warming_up,
  // cooling_down, hv_ready, remote_ctl, time_seconds[42:11], zero fill
  input  wire  [tps_pkg::IN_TDATA_W-1:0] in_tdata,
  // command
  input  wire                            in_tuser,
  output logic                           item_valid,
  input  wire                            item_ready,
  output tps_pkg::tps_item_t             item
);
  import tps_pkg::*;

  logic      valid_r;
  tps_item_t item_r;
  tps_item_t item_nxt;

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.req   = in_tdata[2:0];
    item_nxt.ok    = in_tdata[3];
    item_nxt.flags = in_tdata[10:4];
    item_nxt.t     = in_tdata[42:11];
    if (in_tuser) begin
      item_nxt.kind = KIND_REPORT;
    end else if (in_tdata[2:0] == REQ_INVALID) begin
      item_nxt.kind = KIND_REQ_INVALID;
    end else begin
      item_nxt.kind = KIND_REQ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/tps_queue.sv =====
`default_nettype none
module tps_queue #(
  parameter int DEPTH = tps_pkg::TPS_QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push_valid,
  output logic               push_ready,
  input  tps_pkg::tps_item_t push_data,
  output logic               pop_valid,
  input  wire                pop_ready,
  output tps_pkg::tps_item_t pop_data
);
  import tps_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tps_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   wr_nxt;
  logic [PW-1:0]   rd_nxt;
  logic [CW-1:0]   cnt_nxt;
  logic            push;
  logic            pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

`include "transmitter_power_sequencer_assert.svh"

  `TPS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count above depth")
  `TPS_ASSERT_NXT(a_push_grows, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "push lost")
  `TPS_ASSERT_NXT(a_head_holds, pop_valid && !pop_ready, pop_valid && $stable(rd_r),
                  "queue head dropped while stalled")

endmodule
`default_nettype wire

// ===== design/tps_back.sv =====
`default_nettype none
module tps_back (
  input  wire                clk,
  input  wire                rst_n,
  input  tps_pkg::tps_cfg_t  cfg,
  input  wire                item_valid,
  output logic               item_ready,
  input  tps_pkg::tps_item_t item,
  output logic               res_valid,
  input  wire                res_ready,
  output logic [2:0]         res_send,
  output logic [4:0]         res_msg,
  output logic               res_done,
  output logic [6:0]         res_flags
);
  import tps_pkg::*;

  tps_step_t   step_r,  step_nxt;
  logic [2:0]  req_r,   req_nxt;
  logic [15:0] cnt_r,   cnt_nxt;
  logic [31:0] lft_r,   lft_nxt;
  logic        lfv_r,   lfv_nxt;
  logic [3:0]  arc_r,   arc_nxt;

  logic        out_valid_r;
  logic [2:0]  out_send_r;
  logic [4:0]  out_msg_r;
  logic        out_done_r;
  logic [6:0]  out_flags_r;

  logic [2:0]  send;
  logic [4:0]  msg;
  logic        done;
  logic [6:0]  flags;

  logic        take;
  logic        is_rep;
  logic        ok, on, stby, fault, warm, cool, hv, remote;
  logic        wait_cond;
  logic        wait_end;
  logic [31:0] base_t;
  logic [31:0] gap;
  logic        gap_over;
  logic        arc_ok;
  logic        auto_fire;

  assign item_ready = !out_valid_r || res_ready;
  assign take       = item_valid && item_ready;

  assign is_rep = item.kind == KIND_REPORT;
  assign ok     = item.ok;
  assign on     = item.flags[FLG_ON];
  assign stby   = item.flags[FLG_STBY];
  assign fault  = item.flags[FLG_FAULT];
  assign warm   = item.flags[FLG_WARM];
  assign cool   = item.flags[FLG_COOL];
  assign hv     = item.flags[FLG_HV];
  assign remote = item.flags[FLG_REMOTE];

  assign base_t    = lfv_r ? lft_r : item.t;
  assign gap       = item.t - base_t;
  assign gap_over  = gap > {24'd0, cfg.fault_window};
  assign arc_ok    = arc_r < cfg.max_resets;
  assign auto_fire = ok && fault && (gap_over || arc_ok);

  always_comb begin
    case (step_r)
      ST_WAIT_ON:    wait_cond = on;
      ST_WAIT_WARM:  wait_cond = !warm;
      ST_OFF_STBY:   wait_cond = stby;
      ST_COOL_START: wait_cond = cool;
      ST_COOL_END:   wait_cond = !cool;
      ST_WAIT_STBY:  wait_cond = stby;
      ST_WAIT_OPER:  wait_cond = hv;
      ST_WAIT_RESET: wait_cond = !fault;
      default:       wait_cond = 1'b0;
    endcase
  end

  assign wait_end = wait_cond || (cnt_r >= cfg.poll_limit);

  // next state
  always_comb begin
    step_nxt = step_r;
    req_nxt  = req_r;
    cnt_nxt  = cnt_r;
    lft_nxt  = lft_r;
    lfv_nxt  = lfv_r;
    arc_nxt  = arc_r;
    case (step_r)
      ST_IDLE: begin
        if (item.kind == KIND_REQ) begin
          step_nxt = ST_CHECK;
          req_nxt  = item.req;
        end else if (is_rep && ok && fault) begin
          if (gap_over) begin
            arc_nxt = 4'd1;
          end else if (arc_ok) begin
            arc_nxt = arc_r + 4'd1;
          end
          lft_nxt = item.t;
          lfv_nxt = 1'b1;
        end
      end
      ST_CHECK: begin
        if (is_rep) begin
          step_nxt = ST_IDLE;
          cnt_nxt  = '0;
          if (ok && remote && req_r != REQ_STATUS) begin
            case (req_r)
              REQ_POWERON:  if (!on) step_nxt = ST_WAIT_ON;
              REQ_POWEROFF: if (on) step_nxt = stby ? ST_COOL_START : ST_OFF_STBY;
              REQ_STANDBY:  if (on && !stby) step_nxt = ST_WAIT_STBY;
              REQ_OPERATE:  if (stby) step_nxt = ST_WAIT_OPER;
              REQ_RESET:    if (on) step_nxt = ST_WAIT_RESET;
              default:      step_nxt = ST_IDLE;
            endcase
          end
        end
      end
      default: begin
        if (is_rep) begin
          if (!ok || step_r == ST_WARM_CHECK) begin
            step_nxt = ST_IDLE;
          end else if (!wait_end) begin
            cnt_nxt = cnt_r + 16'd1;
          end else begin
            step_nxt = ST_IDLE;
            cnt_nxt  = '0;
            case (step_r)
              ST_WAIT_ON:    if (!fault && on) step_nxt = ST_WAIT_WARM;
              ST_WAIT_WARM:  step_nxt = ST_WARM_CHECK;
              ST_OFF_STBY:   if (stby) step_nxt = ST_COOL_START;
              ST_COOL_START: if (cool) step_nxt = ST_COOL_END;
              default:       step_nxt = ST_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  // result
  always_comb begin
    send  = SEND_NONE;
    msg   = MSG_NONE;
    done  = 1'b0;
    flags = '0;
    case (step_r)
      ST_IDLE: begin
        case (item.kind)
          KIND_REQ_INVALID: begin
            msg  = MSG_BAD_REQUEST;
            done = 1'b1;
          end
          KIND_REQ: send = SEND_POLL;
          KIND_REPORT: begin
            if (auto_fire) begin
              send = SEND_RESET;
              msg  = MSG_AUTO_RESET;
            end
          end
          default: send = SEND_NONE;
        endcase
      end
      ST_CHECK: begin
        if (is_rep) begin
          done = 1'b1;
          if (!ok) begin
            msg = MSG_LOCAL;
          end else if (req_r == REQ_STATUS) begin
            msg   = MSG_STATUS;
            flags = item.flags;
          end else if (!remote) begin
            msg = MSG_LOCAL;
          end else begin
            case (req_r)
              REQ_POWERON: begin
                if (on) begin
                  msg = MSG_ALREADY_ON;
                end else begin
                  send = SEND_POWERON; msg = MSG_SENT; done = 1'b0;
                end
              end
              REQ_POWEROFF: begin
                if (!on) begin
                  msg = MSG_ALREADY_OFF;
                end else if (!stby) begin
                  send = SEND_STANDBY; msg = MSG_SENT; done = 1'b0;
                end else begin
                  send = SEND_POWEROFF; msg = MSG_COOLING; done = 1'b0;
                end
              end
              REQ_STANDBY: begin
                if (on && !stby) begin
                  send = SEND_STANDBY; msg = MSG_SENT; done = 1'b0;
                end else begin
                  msg = on ? MSG_ALREADY_STBY : MSG_TX_OFF;
                end
              end
              REQ_OPERATE: begin
                if (stby) begin
                  send = SEND_OPERATE; msg = MSG_SENT; done = 1'b0;
                end else begin
                  msg = on ? MSG_ALREADY_OPER : MSG_TX_OFF;
                end
              end
              REQ_RESET: begin
                if (on) begin
                  send = SEND_RESET; msg = MSG_SENT; done = 1'b0;
                end else begin
                  msg = MSG_TX_OFF;
                end
              end
              default: msg = MSG_UNKNOWN_CMD;
            endcase
          end
        end
      end
      default: begin
        if (is_rep) begin
          if (!ok) begin
            msg  = MSG_ABORT;
            done = 1'b1;
          end else if (step_r == ST_WARM_CHECK) begin
            msg  = stby ? MSG_WARM_STBY : MSG_WARM_NO_STBY;
            done = 1'b1;
          end else if (!wait_end) begin
            send = SEND_POLL;
          end else begin
            done = 1'b1;
            case (step_r)
              ST_WAIT_ON: begin
                if (fault) begin
                  msg = MSG_FAULT;
                end else if (on) begin
                  send = SEND_POLL; msg = MSG_WARMING; done = 1'b0;
                end else begin
                  msg = MSG_NOT_ON;
                end
              end
              ST_WAIT_WARM: begin
                send = SEND_POLL; done = 1'b0;
              end
              ST_OFF_STBY: begin
                if (stby) begin
                  send = SEND_POWEROFF; msg = MSG_COOLING; done = 1'b0;
                end else begin
                  msg = MSG_NO_STBY;
                end
              end
              ST_COOL_START: begin
                if (cool) begin
                  send = SEND_POLL; done = 1'b0;
                end else begin
                  msg = MSG_STBY_NO_COOL;
                end
              end
              ST_COOL_END:   msg = MSG_COOL_DONE;
              ST_WAIT_STBY:  msg = fault ? MSG_FAULT : (stby ? MSG_IN_STBY : MSG_NO_STBY);
              ST_WAIT_OPER:  msg = fault ? MSG_FAULT : (hv ? MSG_IN_OPER : MSG_NO_OPER);
              ST_WAIT_RESET: msg = fault ? MSG_FAULT :
                                   (stby ? MSG_RESET_DONE : MSG_RESET_FAIL);
              default:       done = 1'b0;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      req_r       <= '0;
      cnt_r       <= '0;
      lft_r       <= '0;
      lfv_r       <= 1'b0;
      arc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        step_r <= step_nxt;
        req_r  <= req_nxt;
        cnt_r  <= cnt_nxt;
        lft_r  <= lft_nxt;
        lfv_r  <= lfv_nxt;
        arc_r  <= arc_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_send_r  <= send;
      out_msg_r   <= msg;
      out_done_r  <= done;
      out_flags_r <= flags;
    end
  end

  assign res_valid = out_valid_r;
  assign res_send  = out_send_r;
  assign res_msg   = out_msg_r;
  assign res_done  = out_done_r;
  assign res_flags = out_flags_r;

`include "transmitter_power_sequencer_assert.svh"

  `TPS_ASSERT_NXT(a_done_idle, take && done, step_r == ST_IDLE, "sequence not ended on done")
  `TPS_ASSERT_IMP(a_poweron_src, take && send == SEND_POWERON, step_r == ST_CHECK,
                  "power on sent outside check")
  `TPS_ASSERT_NXT(a_busy_ignore, take && !is_rep && step_r != ST_IDLE,
                  out_send_r == SEND_NONE && !out_done_r && out_msg_r == MSG_NONE,
                  "request while busy not ignored")

endmodule
`default_nettype wire

// ===== design/transmitter_power_sequencer.sv =====
`default_nettype none
// Path: out_tvalid is registered; an accepted beat passes the input register,
//   the queue, then the sequencer output register.
// Throughput: 1 beat per cycle while out_tready is high; one state step per beat.
// Reset: synchronous, active low; sequencer returns to idle, fault history and
//   auto-reset count clear, the queue empties and registers take their defaults.
module transmitter_power_sequencer #(
  parameter int QUEUE_DEPTH = tps_pkg::TPS_QUEUE_DEPTH
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // request[2:0], poll_ok, unit_on, in_standby, fault_summary, warming_up,
  // cooling_down, hv_ready, remote_ctl, time_seconds[42:11], zero fill
  input  wire  [tps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // tx_send[2:0], message[7:3], status_flags[14:8], zero fill
  output logic [tps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // message_valid
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  wire                             cfg_we,
  input  wire  [tps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [tps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tps_pkg::*;

  tps_cfg_t  cfg_r;
  logic      f_valid, f_ready;
  tps_item_t f_item;
  logic      q_valid, q_ready;
  tps_item_t q_item;
  logic [2:0] res_send;
  logic [4:0] res_msg;
  logic [6:0] res_flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_limit   <= POLL_LIMIT_RST;
      cfg_r.fault_window <= FAULT_WINDOW_RST;
      cfg_r.max_resets   <= MAX_RESETS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_POLL_LIMIT:   cfg_r.poll_limit   <= cfg_wdata;
        CFG_FAULT_WINDOW: cfg_r.fault_window <= cfg_wdata[7:0];
        CFG_MAX_RESETS:   cfg_r.max_resets   <= cfg_wdata[3:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  tps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  tps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_item)
  );

  tps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_send   (res_send),
    .res_msg    (res_msg),
    .res_done   (out_tlast),
    .res_flags  (res_flags)
  );

  assign out_tdata = {1'b0, res_flags, res_msg, res_send};
  assign out_tuser = res_msg != MSG_NONE;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  import tps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 100;
  localparam int HOLD_CYCLES = 150;

  localparam logic       CMD_REQUEST = 1'b0;
  localparam logic       CMD_REPORT  = 1'b1;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  localparam logic [6:0] F_ON     = 7'(1 << FLG_ON);
  localparam logic [6:0] F_STBY   = 7'(1 << FLG_STBY);
  localparam logic [6:0] F_FAULT  = 7'(1 << FLG_FAULT);
  localparam logic [6:0] F_COOL   = 7'(1 << FLG_COOL);
  localparam logic [6:0] F_REMOTE = 7'(1 << FLG_REMOTE);

  typedef struct packed {
    logic [2:0] send;
    logic [4:0] msg;
    logic       done;
    logic [6:0] flags;
  } reply_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

  class tx_sequencer_checker;
    logic [15:0] poll_limit;
    logic [7:0]  fault_window;
    logic [3:0]  max_resets;
    tps_step_t   step;
    logic [2:0]  active_req;
    logic [15:0] wait_cnt;
    logic [31:0] last_fault_t;
    bit          fault_seen;
    logic [3:0]  reset_cnt;
    reply_t      pending_replies[$];
    reply_t      r;
    int          errors;
    int          useful_beats;

    function new();
      poll_limit   = POLL_LIMIT_RST;
      fault_window = FAULT_WINDOW_RST;
      max_resets   = MAX_RESETS_RST;
      step         = ST_IDLE;
      active_req   = REQ_INVALID;
      wait_cnt     = '0;
      last_fault_t = '0;
      fault_seen   = 1'b0;
      reset_cnt    = '0;
      errors       = 0;
      useful_beats = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      case (addr)
        CFG_POLL_LIMIT:   poll_limit = value;
        CFG_FAULT_WINDOW: fault_window = value[7:0];
        CFG_MAX_RESETS:   max_resets = value[3:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [2:0] send, logic [4:0] msg, logic done);
      r.send  = send;
      r.msg   = msg;
      r.done  = done;
      r.flags = '0;
    endfunction

    function void finish(logic [4:0] msg);
      emit(SEND_NONE, msg, 1'b1);
      step = ST_IDLE;
    endfunction

    function void start_wait(tps_step_t nxt, logic [2:0] send, logic [4:0] msg);
      emit(send, msg, 1'b0);
      step = nxt;
      wait_cnt = '0;
    endfunction

    // wait ends on the flag or at the poll limit; otherwise ask for one more poll
    function bit poll_done(logic cond);
      if (cond || wait_cnt >= poll_limit)
        return 1'b1;
      wait_cnt = wait_cnt + 16'd1;
      emit(SEND_POLL, MSG_NONE, 1'b0);
      return 1'b0;
    endfunction

    function void log_accepted(logic cmd, logic [IN_TDATA_W-1:0] d);
      logic [2:0]  req;
      logic        ok, on, stby, fault, warm, cool, hv, remote;
      logic [6:0]  flg;
      logic [31:0] t, gap;
      req    = d[2:0];
      ok     = d[3];
      flg    = d[10:4];
      t      = d[42:11];
      on     = flg[FLG_ON];
      stby   = flg[FLG_STBY];
      fault  = flg[FLG_FAULT];
      warm   = flg[FLG_WARM];
      cool   = flg[FLG_COOL];
      hv     = flg[FLG_HV];
      remote = flg[FLG_REMOTE];
      emit(SEND_NONE, MSG_NONE, 1'b0);
      if (cmd == CMD_REQUEST) begin
        if (step == ST_IDLE) begin
          useful_beats++;
          if (req == REQ_INVALID) begin
            emit(SEND_NONE, MSG_BAD_REQUEST, 1'b1);
          end else begin
            active_req = req;
            step = ST_CHECK;
            emit(SEND_POLL, MSG_NONE, 1'b0);
          end
        end
      end else if (step == ST_IDLE) begin
        if (ok && fault) begin
          useful_beats++;
          if (!fault_seen)
            last_fault_t = t;
          gap = t - last_fault_t;
          if (gap > {24'd0, fault_window}) begin
            reset_cnt = 4'd1;
            emit(SEND_RESET, MSG_AUTO_RESET, 1'b0);
          end else if (reset_cnt < max_resets) begin
            reset_cnt = reset_cnt + 4'd1;
            emit(SEND_RESET, MSG_AUTO_RESET, 1'b0);
          end
          last_fault_t = t;
          fault_seen = 1'b1;
        end
      end else if (step == ST_CHECK) begin
        useful_beats++;
        if (!ok) begin
          finish(MSG_LOCAL);
        end else if (active_req == REQ_STATUS) begin
          finish(MSG_STATUS);
          r.flags = flg;
        end else if (!remote) begin
          finish(MSG_LOCAL);
        end else begin
          case (active_req)
            REQ_POWERON:
              if (on) finish(MSG_ALREADY_ON);
              else start_wait(ST_WAIT_ON, SEND_POWERON, MSG_SENT);
            REQ_POWEROFF:
              if (!on) finish(MSG_ALREADY_OFF);
              else if (!stby) start_wait(ST_OFF_STBY, SEND_STANDBY, MSG_SENT);
              else start_wait(ST_COOL_START, SEND_POWEROFF, MSG_COOLING);
            REQ_STANDBY:
              if (on && !stby) start_wait(ST_WAIT_STBY, SEND_STANDBY, MSG_SENT);
              else if (!on) finish(MSG_TX_OFF);
              else finish(MSG_ALREADY_STBY);
            REQ_OPERATE:
              if (stby) start_wait(ST_WAIT_OPER, SEND_OPERATE, MSG_SENT);
              else if (!on) finish(MSG_TX_OFF);
              else finish(MSG_ALREADY_OPER);
            REQ_RESET:
              if (on) start_wait(ST_WAIT_RESET, SEND_RESET, MSG_SENT);
              else finish(MSG_TX_OFF);
            default: finish(MSG_UNKNOWN_CMD);
          endcase
        end
      end else begin
        useful_beats++;
        if (!ok) begin
          finish(MSG_ABORT);
        end else begin
          case (step)
            ST_WAIT_ON:
              if (poll_done(on)) begin
                if (fault) finish(MSG_FAULT);
                else if (on) start_wait(ST_WAIT_WARM, SEND_POLL, MSG_WARMING);
                else finish(MSG_NOT_ON);
              end
            ST_WAIT_WARM:
              if (poll_done(!warm)) start_wait(ST_WARM_CHECK, SEND_POLL, MSG_NONE);
            ST_WARM_CHECK:
              finish(stby ? MSG_WARM_STBY : MSG_WARM_NO_STBY);
            ST_OFF_STBY:
              if (poll_done(stby)) begin
                if (stby) start_wait(ST_COOL_START, SEND_POWEROFF, MSG_COOLING);
                else finish(MSG_NO_STBY);
              end
            ST_COOL_START:
              if (poll_done(cool)) begin
                if (cool) start_wait(ST_COOL_END, SEND_POLL, MSG_NONE);
                else finish(MSG_STBY_NO_COOL);
              end
            ST_COOL_END:
              if (poll_done(!cool)) finish(MSG_COOL_DONE);
            ST_WAIT_STBY:
              if (poll_done(stby))
                finish(fault ? MSG_FAULT : (stby ? MSG_IN_STBY : MSG_NO_STBY));
            ST_WAIT_OPER:
              if (poll_done(hv))
                finish(fault ? MSG_FAULT : (hv ? MSG_IN_OPER : MSG_NO_OPER));
            ST_WAIT_RESET:
              if (poll_done(!fault))
                finish(fault ? MSG_FAULT : (stby ? MSG_RESET_DONE : MSG_RESET_FAIL));
            default: step = ST_IDLE;
          endcase
        end
      end
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP)
        $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_reply(logic [OUT_TDATA_W-1:0] data, logic user, logic last);
      reply_t e;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", data));
        return;
      end
      e = pending_replies.pop_front();
      if (data[2:0] !== e.send)
        report_mismatch($sformatf("tx_send %0d, expected %0d", data[2:0], e.send));
      if (data[7:3] !== e.msg)
        report_mismatch($sformatf("message %0d, expected %0d", data[7:3], e.msg));
      if (user !== (e.msg != MSG_NONE))
        report_mismatch($sformatf("message_valid %b for message %0d", user, e.msg));
      if (last !== e.done)
        report_mismatch($sformatf("done %b, expected %b", last, e.done));
      if (data[14:8] !== e.flags)
        report_mismatch($sformatf("status_flags %h, expected %h", data[14:8], e.flags));
      if (data[15] !== 1'b0)
        report_mismatch("fill bit of out_tdata set");
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  transmitter_power_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tx_sequencer_checker sb;

  initial begin
    forever #1 clk = ~clk;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check, then pick next ready
  int       holds_asked = 0;
  int       holds_seen = 0;
  int       hold_left = 0;
  int       rx_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_reply(out_tdata, out_tuser, out_tlast);
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_COIN:  out_tready <= ($urandom_range(0, 1) == 1);
        RX_SLOW:  out_tready <= ($urandom_range(0, 4) == 0);
        default:  out_tready <= (rx_left % 3 != 0);
      endcase
    end
  end

  // command side
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  logic [31:0] now_s = '0;

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [2:0] req, logic ok,
                                                       logic [6:0] flg, logic [31:0] t);
    return {5'd0, t, flg, ok, req};
  endfunction

  function automatic logic [31:0] next_report_time();
    if ($urandom_range(0, 40) == 0)
      now_s = $urandom();
    else if ($urandom_range(0, 9) == 0)
      now_s = now_s + $urandom_range(0, 300);
    else
      now_s = now_s + $urandom_range(0, 4);
    return now_s;
  endfunction

  task automatic push_beat(input logic cmd, input logic [IN_TDATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.log_accepted(cmd, d);
    burst_left--;
  endtask

  task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(addr, value);
  endtask

  task automatic write_regs(input logic [15:0] pl, input logic [7:0] fw, input logic [3:0] mr);
    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    put_reg(CFG_POLL_LIMIT, pl);
    put_reg(CFG_FAULT_WINDOW, {8'd0, fw});
    put_reg(CFG_MAX_RESETS, {12'd0, mr});
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    push_beat(CMD_REQUEST, pack_item(REQ_INVALID, 1'b0, '0, '0));
    push_beat(CMD_REQUEST, pack_item(REQ_STATUS, 1'b0, '0, '0));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, 7'h7f, 32'hffff_ffff));
    push_beat(CMD_REQUEST, pack_item(REQ_UNKNOWN, 1'b1, 7'h7f, 32'hffff_ffff));
    push_beat(CMD_REPORT, pack_item(REQ_UNKNOWN, 1'b1, F_REMOTE, 32'd5));
    // failed first poll
    push_beat(CMD_REQUEST, pack_item(REQ_POWERON, 1'b0, '0, '0));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b0, F_REMOTE, 32'd6));
    // local mode
    push_beat(CMD_REQUEST, pack_item(REQ_STANDBY, 1'b0, '0, '0));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_ON, 32'd7));
    // power on, request while busy, then abort
    push_beat(CMD_REQUEST, pack_item(REQ_POWERON, 1'b0, '0, '0));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_REMOTE, 32'd8));
    push_beat(CMD_REQUEST, pack_item(REQ_STATUS, 1'b0, '0, '0));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b0, F_REMOTE, 32'd9));
    // power off from standby through cool down
    push_beat(CMD_REQUEST, pack_item(REQ_POWEROFF, 1'b0, '0, '0));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_ON | F_STBY | F_REMOTE, 32'd10));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_STBY | F_COOL | F_REMOTE, 32'd11));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_STBY | F_REMOTE, 32'd12));
    // auto-reset budget, then a gap past the window, then a bad frame
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_FAULT, 32'd100));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_FAULT, 32'd101));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_FAULT, 32'd102));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_FAULT, 32'd103));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b1, F_FAULT, 32'd200));
    push_beat(CMD_REPORT, pack_item(3'd0, 1'b0, F_FAULT, 32'd201));
  endtask

  task automatic run_command();
    logic [2:0] req;
    logic [6:0] flg;
    int         pick, bias, polls;
    pick = $urandom_range(0, 19);
    if (pick == 0) req = REQ_INVALID;
    else if (pick == 1) req = REQ_UNKNOWN;
    else if (pick < 4) req = REQ_STATUS;
    else req = 3'($urandom_range(REQ_POWERON, REQ_RESET));
    bias = $urandom_range(0, 2);
    push_beat(CMD_REQUEST, pack_item(req, 1'($urandom()), 7'($urandom()), $urandom()));
    polls = 0;
    while (sb.step != ST_IDLE && polls < 60) begin
      if (sb.step == ST_CHECK) begin
        flg = 7'($urandom());
        if ($urandom_range(0, 9) != 0) flg[FLG_REMOTE] = 1'b1;
      end else if (bias == 1) begin
        flg = 7'($urandom()) & 7'($urandom());
      end else if (bias == 2) begin
        flg = 7'($urandom()) | 7'($urandom());
      end else begin
        flg = 7'($urandom());
      end
      if ($urandom_range(0, 24) == 0)
        push_beat(CMD_REQUEST, pack_item(3'($urandom()), 1'b1, 7'($urandom()), $urandom()));
      push_beat(CMD_REPORT, pack_item(3'($urandom()), $urandom_range(0, 15) != 0, flg,
                                      next_report_time()));
      polls++;
    end
  endtask

  task automatic idle_faults();
    int         n;
    logic [6:0] flg;
    n = $urandom_range(1, 4);
    repeat (n) begin
      flg = 7'($urandom());
      flg[FLG_FAULT] = ($urandom_range(0, 9) < 7);
      push_beat(CMD_REPORT, pack_item(3'($urandom()), $urandom_range(0, 9) != 0, flg,
                                      next_report_time()));
    end
  endtask

  task automatic run_phase(input int beats, input bit steady);
    int goal;
    no_gaps = steady;
    goal = sb.useful_beats + beats;
    holds_asked++;
    while (sb.useful_beats < goal) begin
      case ($urandom_range(0, 9))
        0: idle_faults();
        1: push_beat(1'($urandom()), {5'd0, 32'($urandom()), 11'($urandom())});
        default: run_command();
      endcase
      if ($urandom_range(0, 150) == 0) holds_asked++;
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    directed();
    write_regs(16'd0, 8'd0, 4'd0);
    run_phase(200, 1'b0);
    write_regs(16'd65535, 8'd255, 4'd15);
    run_phase(200, 1'b1);
    write_regs(16'd3, 8'd10, 4'd1);
    run_phase(250, 1'b0);
    repeat (2) begin
      write_regs(16'($urandom_range(0, 8)), 8'($urandom()), 4'($urandom()));
      run_phase(230, 1'b0);
    end
    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
